// File: design/quadratic_root_solver_assert.svh
// Assertion macros for the quadratic root solver.
// Used by the top level only; no other dependencies.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: design/qrs_pkg.sv
// Shared widths, codes and pipeline types for the quadratic root solver.
// No dependencies.
`default_nettype none
package qrs_pkg;
  localparam int CW   = 16;
  localparam int FB   = 16;
  localparam int RW   = 32;
  localparam int DW   = 2 * CW + 2;
  localparam int SW   = CW + 1;
  localparam int NW   = CW + 2;
  localparam int DVW  = CW + 1;
  localparam int QW   = NW + FB;
  localparam int SQ_STAGES  = SW;
  localparam int DIV_STAGES = QW;

  typedef enum logic [1:0] {
    KIND_INF = 2'd0, KIND_NONE = 2'd1, KIND_ONE = 2'd2, KIND_TWO = 2'd3
  } kind_t;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [SW-1:0] root;
    logic [DW-1:0] dsc;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    kind_t kind;
    logic  vld;
  } sq_t;

  typedef struct packed {
    logic [QW-1:0]  rem1;
    logic [QW-1:0]  q1;
    logic [QW-1:0]  n1;
    logic           neg1;
    logic [QW-1:0]  rem2;
    logic [QW-1:0]  q2;
    logic [QW-1:0]  n2;
    logic           neg2;
    logic [DVW-1:0] den;
    kind_t kind;
    logic  vld;
  } dv_t;
endpackage
`default_nettype wire

// File: design/qrs_sqrt_cell.sv
// One restoring square-root cell: resolves one root bit per cycle while adv is high.
// Depends on qrs_pkg.
`default_nettype none
module qrs_sqrt_cell import qrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic [$clog2(SW)-1:0] bit_pos,
  input  wire sq_t  din,
  output sq_t       dout
);
  logic [DW-1:0] rem2;
  logic [DW-1:0] trial;
  sq_t nxt;
  always_comb begin
    nxt = din;
    rem2 = {din.rem[DW-3:0], din.dsc[2*bit_pos +: 2]};
    trial = {{(DW-SW-2){1'b0}}, din.root, 2'b01};
    if (rem2 >= trial) begin
      nxt.rem = rem2 - trial;
      nxt.root = {din.root[SW-2:0], 1'b1};
    end else begin
      nxt.rem = rem2;
      nxt.root = {din.root[SW-2:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (adv) begin
      dout.vld <= din.vld;
    end
    if (adv) begin
      dout.rem <= nxt.rem; dout.root <= nxt.root; dout.dsc <= nxt.dsc;
      dout.a <= nxt.a; dout.b <= nxt.b; dout.c <= nxt.c; dout.kind <= nxt.kind;
    end
  end
endmodule
`default_nettype wire

// File: design/qrs_div_cell.sv
// One restoring division cell: one quotient bit per cycle for both roots while adv is high.
// Depends on qrs_pkg.
`default_nettype none
module qrs_div_cell import qrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic adv,
  input  wire logic [$clog2(QW)-1:0] bit_pos,
  input  wire dv_t  din,
  output dv_t       dout
);
  logic [QW:0] r1, r2;
  dv_t nxt;
  always_comb begin
    nxt = din;
    r1 = {din.rem1, din.n1[bit_pos]};
    r2 = {din.rem2, din.n2[bit_pos]};
    if (r1 >= {{(QW+1-DVW){1'b0}}, din.den}) begin
      nxt.rem1 = QW'(r1 - {{(QW+1-DVW){1'b0}}, din.den});
      nxt.q1 = {din.q1[QW-2:0], 1'b1};
    end else begin
      nxt.rem1 = r1[QW-1:0];
      nxt.q1 = {din.q1[QW-2:0], 1'b0};
    end
    if (r2 >= {{(QW+1-DVW){1'b0}}, din.den}) begin
      nxt.rem2 = QW'(r2 - {{(QW+1-DVW){1'b0}}, din.den});
      nxt.q2 = {din.q2[QW-2:0], 1'b1};
    end else begin
      nxt.rem2 = r2[QW-1:0];
      nxt.q2 = {din.q2[QW-2:0], 1'b0};
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (adv) begin
      dout.vld <= din.vld;
    end
    if (adv) begin
      dout.rem1 <= nxt.rem1; dout.q1 <= nxt.q1; dout.n1 <= nxt.n1;
      dout.neg1 <= nxt.neg1; dout.rem2 <= nxt.rem2; dout.q2 <= nxt.q2;
      dout.n2 <= nxt.n2; dout.neg2 <= nxt.neg2; dout.den <= nxt.den;
      dout.kind <= nxt.kind;
    end
  end
endmodule
`default_nettype wire

// File: design/quadratic_root_solver.sv
// Top level: discriminant stages, square-root cell chain, divider cell chain.
// Depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the assert header.
// Beat path: input, discriminant, sqrt cells, numerator, divider cells, output.
// Throughput: one beat per cycle; the whole pipe advances unless the output
// register holds a beat that is stalled. Reset (rst, synchronous) clears
// all valid bits; no memories, no clearing pass.
`default_nettype none
`include "quadratic_root_solver_assert.svh"
module quadratic_root_solver import qrs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [CW-1:0] coef_a,
  input  wire logic signed [CW-1:0] coef_b,
  input  wire logic signed [CW-1:0] coef_c,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [1:0] root_kind,
  output logic signed [RW-1:0] root_x1,
  output logic signed [RW-1:0] root_x2,
  output logic      saturated
);
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: register inputs and products
  logic v1;
  logic signed [CW-1:0] a1, b1, c1;
  logic [2*CW-1:0] bb1, ac1;
  logic acpos1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      a1 <= coef_a; b1 <= coef_b; c1 <= coef_c;
      bb1 <= (2*CW)'($signed({{CW{coef_b[CW-1]}}, coef_b}) *
                     $signed({{CW{coef_b[CW-1]}}, coef_b}));
      ac1 <= (2*CW)'($unsigned(coef_a[CW-1] ? -{{CW{coef_a[CW-1]}}, coef_a}
                                             : {{CW{1'b0}}, coef_a}) *
                     $unsigned(coef_c[CW-1] ? -{{CW{coef_c[CW-1]}}, coef_c}
                                             : {{CW{1'b0}}, coef_c}));
      acpos1 <= (coef_a[CW-1] == coef_c[CW-1]) && coef_a != '0 && coef_c != '0;
    end
  end

  // stage 2: discriminant and kind
  logic v2;
  logic signed [CW-1:0] a2, b2, c2;
  logic [DW-1:0] d2;
  kind_t k2;
  logic [DW-1:0] bbw, acw;
  kind_t kn;
  logic [DW-1:0] dn;
  always_comb begin
    bbw = {2'b00, bb1};
    acw = {ac1, 2'b00};
    dn = '0;
    if (a1 == '0) begin
      if (b1 == '0) kn = (c1 == '0) ? KIND_INF : KIND_NONE;
      else kn = KIND_ONE;
    end else if (!acpos1) begin
      dn = bbw + acw;
      kn = (dn == '0) ? KIND_ONE : KIND_TWO;
    end else if (bbw >= acw) begin
      dn = bbw - acw;
      kn = (dn == '0) ? KIND_ONE : KIND_TWO;
    end else begin
      kn = KIND_NONE;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      a2 <= a1; b2 <= b1; c2 <= c1; d2 <= dn; k2 <= kn;
    end
  end

  // square-root chain
  sq_t sq [SQ_STAGES+1];
  assign sq[0] = '{rem: '0, root: '0, dsc: d2, a: a2, b: b2, c: c2, kind: k2, vld: v2};
  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .bit_pos($clog2(SW)'(SQ_STAGES - 1 - i)),
      .din(sq[i]), .dout(sq[i+1])
    );
  end

  // stage 3: numerators and divisor
  sq_t sl;
  assign sl = sq[SQ_STAGES];
  logic signed [NW-1:0] nb, ns, num1, num2;
  logic lin;
  always_comb begin
    lin = (sl.a == '0);
    nb = -NW'(sl.b);
    ns = NW'($signed({1'b0, sl.root}));
    num1 = lin ? -NW'(sl.c) : nb - ns;
    num2 = nb + ns;
  end
  dv_t dv0;
  dv_t dv [DIV_STAGES+1];
  assign dv[0] = dv0;
  always_ff @(posedge clk) begin
    if (rst) dv0.vld <= 1'b0;
    else if (adv) dv0.vld <= sl.vld;
    if (adv) begin
      dv0.kind <= sl.kind;
      dv0.rem1 <= '0; dv0.q1 <= '0; dv0.rem2 <= '0; dv0.q2 <= '0;
      dv0.n1 <= {(num1[NW-1] ? -num1 : num1), {FB{1'b0}}};
      dv0.n2 <= {(num2[NW-1] ? -num2 : num2), {FB{1'b0}}};
      if (lin) begin
        dv0.neg1 <= (num1 != '0) && (num1[NW-1] != sl.b[CW-1]);
        dv0.den <= sl.b[CW-1] ? DVW'(-$signed({sl.b[CW-1], sl.b})) : DVW'(sl.b);
      end else begin
        dv0.neg1 <= (num1 != '0) && (num1[NW-1] != sl.a[CW-1]);
        dv0.den <= sl.a[CW-1] ? DVW'(-$signed({sl.a[CW-1], sl.a})) << 1
                              : DVW'(sl.a) << 1;
      end
      dv0.neg2 <= (num2 != '0) && (num2[NW-1] != sl.a[CW-1]);
    end
  end
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .bit_pos($clog2(QW)'(DIV_STAGES - 1 - j)),
      .din(dv[j]), .dout(dv[j+1])
    );
  end

  // output: sign, saturate, select
  dv_t dl;
  assign dl = dv[DIV_STAGES];
  logic [RW-1:0] r1, r2;
  logic s1, s2;
  always_comb begin
    if (dl.neg1) begin
      s1 = dl.q1 > QW'(33'h080000000);
      r1 = s1 ? 32'h80000000 : RW'(-dl.q1);
    end else begin
      s1 = dl.q1 > QW'(32'h7FFFFFFF);
      r1 = s1 ? 32'h7FFFFFFF : RW'(dl.q1);
    end
    if (dl.neg2) begin
      s2 = dl.q2 > QW'(33'h080000000);
      r2 = s2 ? 32'h80000000 : RW'(-dl.q2);
    end else begin
      s2 = dl.q2 > QW'(32'h7FFFFFFF);
      r2 = s2 ? 32'h7FFFFFFF : RW'(dl.q2);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= dl.vld;
    if (adv) begin
      root_kind <= dl.kind;
      case (dl.kind)
        KIND_ONE: begin
          root_x1 <= r1; root_x2 <= '0; saturated <= s1;
        end
        KIND_TWO: begin
          root_x1 <= r1; root_x2 <= r2; saturated <= s1 | s2;
        end
        default: begin
          root_x1 <= '0; root_x2 <= '0; saturated <= 1'b0;
        end
      endcase
    end
  end

  `QRS_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(root_x1), "stalled beat changed")
  `QRS_ASSERT_IMP(a_inf_clean, out_valid && (root_kind == KIND_INF || root_kind == KIND_NONE), root_x1 == '0 && !saturated, "absent root not zero")
  `QRS_ASSERT_IMP(a_one_clean, out_valid && root_kind == KIND_ONE, root_x2 == '0, "second root set for one root")
endmodule
`default_nettype wire

// File: dv/tb.sv
// Testbench for quadratic_root_solver: directed table then random coefficient beats.
// Checks beats against typed rows or an in-bench predictor; depends on qrs_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import qrs_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic signed [15:0] coef_a = 0, coef_b = 0, coef_c = 0;
  logic in_stall, out_valid, saturated;
  logic [1:0] root_kind;
  logic signed [31:0] root_x1, root_x2;

  quadratic_root_solver u_dut (.*);

  typedef struct {
    kind_t kind;
    logic [31:0] r1, r2;
    logic sat;
  } roots_t;

  typedef struct {
    logic [15:0] a, b, c;
    bit typed;
    roots_t want;
  } row_t;

  roots_t pending_roots[$];
  int errors = 0, idle_cycles = 0;
  bit stim_done = 0, hold_long = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [31:0] scaled_quot(bit neg, logic [63:0] n, logic [63:0] d,
                                               inout bit sat);
    logic [63:0] q;
    q = (n << 16) / d;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        q = 64'h8000_0000;
        sat = 1;
      end
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) begin
      q = 64'h7fff_ffff;
      sat = 1;
    end
    return q[31:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [67:0] v);
    logic [67:0] r, bt, t;
    r = 0;
    bt = 68'h1 << 66;
    while (bt != 0 && bt > v) bt = bt >> 2;
    while (bt != 0) begin
      t = r + bt;
      if (v >= t) begin
        v = v - t;
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] mag64(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  function automatic roots_t solve_roots(logic [15:0] ai, logic [15:0] bi, logic [15:0] ci);
    roots_t r;
    longint a, b, c, d, s, n1, n2;
    bit sat;
    a = longint'($signed(ai));
    b = longint'($signed(bi));
    c = longint'($signed(ci));
    sat = 0;
    r.r1 = 0;
    r.r2 = 0;
    if (a == 0) begin
      if (b == 0) begin
        r.kind = (c == 0) ? KIND_INF : KIND_NONE;
      end else begin
        r.kind = KIND_ONE;
        r.r1 = scaled_quot((c < 0) == (b < 0) && c != 0, mag64(c), mag64(b), sat);
      end
    end else begin
      d = b * b - 4 * a * c;
      if (d < 0) begin
        r.kind = KIND_NONE;
      end else if (d == 0) begin
        r.kind = KIND_ONE;
        r.r1 = scaled_quot((-b < 0) != (a < 0), mag64(-b), 2 * mag64(a), sat);
      end else begin
        r.kind = KIND_TWO;
        s = longint'(floor_sqrt(68'(d)));
        n1 = -b - s;
        n2 = -b + s;
        r.r1 = scaled_quot((n1 < 0) != (a < 0), mag64(n1), 2 * mag64(a), sat);
        r.r2 = scaled_quot((n2 < 0) != (a < 0), mag64(n2), 2 * mag64(a), sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic row_t mk(int a, int b, int c, bit typed = 0, kind_t k = KIND_INF,
                              logic [31:0] r1 = 0, logic [31:0] r2 = 0, bit s = 0);
    row_t w;
    w.a = 16'(a);
    w.b = 16'(b);
    w.c = 16'(c);
    w.typed = typed;
    w.want = '{k, r1, r2, s};
    return w;
  endfunction

  task automatic send_beat(row_t w);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    coef_a <= w.a;
    coef_b <= w.b;
    coef_c <= w.c;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_roots.push_back(w.typed ? w.want : solve_roots(w.a, w.b, w.c));
    @(negedge clk);
  endtask

  initial begin
    row_t plan[$];
    int mode;
    logic [15:0] a, b, c;
    repeat (3) @(negedge clk);
    rst = 0;
    plan.push_back(mk(0, 0, 0, 1, KIND_INF));
    plan.push_back(mk(0, 0, 256, 1, KIND_NONE));
    plan.push_back(mk(0, 0, -32768, 1, KIND_NONE));
    plan.push_back(mk(0, 256, -512, 1, KIND_ONE, 32'h0002_0000));
    plan.push_back(mk(0, 1, 32767, 1, KIND_ONE, 32'h8001_0000));
    plan.push_back(mk(0, -1, 32767, 1, KIND_ONE, 32'h7fff_0000));
    plan.push_back(mk(0, 1, -32768, 1, KIND_ONE, 32'h7fff_ffff, 0, 1));
    plan.push_back(mk(0, -1, -32768, 1, KIND_ONE, 32'h8000_0000));
    plan.push_back(mk(0, -32768, -32768, 1, KIND_ONE, 32'hffff_0000));
    plan.push_back(mk(256, 0, 256, 1, KIND_NONE));
    plan.push_back(mk(256, -512, 256, 1, KIND_ONE, 32'h0001_0000));
    plan.push_back(mk(256, 0, -256, 1, KIND_TWO, 32'hffff_0000, 32'h0001_0000));
    plan.push_back(mk(1, -32768, 0));
    plan.push_back(mk(1, 32767, -32768));
    plan.push_back(mk(-1, 32767, 32767));
    plan.push_back(mk(-32768, -32768, -32768));
    plan.push_back(mk(32767, 32767, 32767));
    plan.push_back(mk(32767, -32768, -32768));
    plan.push_back(mk(-32768, 0, 32767));
    plan.push_back(mk(-32768, 0, -32768));
    plan.push_back(mk(-1, 0, 0));
    plan.push_back(mk(1, 2, 1));
    plan.push_back(mk(-32768, 32767, 0));
    foreach (plan[i]) send_beat(plan[i]);
    for (int i = 0; i < 1600; i++) begin
      mode = $urandom_range(0, 9);
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      if (mode == 0) a = 0;
      if (mode == 1) begin
        a = 0;
        b = 0;
      end
      if (mode == 2) begin
        a = 16'($signed(8'($urandom)));
        b = 16'($signed(8'($urandom)));
        c = 16'($signed(8'($urandom)));
      end
      if (mode == 3) a = 16'($urandom_range(0, 1)) ? 16'h0001 : 16'hffff;
      if (i == 300) hold_long = 1;
      send_beat(mk(a, b, c));
    end
    in_valid <= 0;
    stim_done = 1;
  end

  initial begin
    int hold;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        hold_long = 0;
        out_stall <= 1;
        repeat (200) @(negedge clk);
      end
      if ($urandom_range(0, 2) == 0) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
        out_stall <= 1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    roots_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d", $time, root_kind);
        errors++;
      end else begin
        w = pending_roots.pop_front();
        if (root_kind !== w.kind) begin
          $display("%0t: root_kind exp %0d got %0d", $time, w.kind, root_kind);
          errors++;
        end
        if (root_x1 !== w.r1) begin
          $display("%0t: root_x1 exp %h got %h", $time, w.r1, root_x1);
          errors++;
        end
        if (root_x2 !== w.r2) begin
          $display("%0t: root_x2 exp %h got %h", $time, w.r2, root_x2);
          errors++;
        end
        if (saturated !== w.sat) begin
          $display("%0t: saturated exp %0d got %0d", $time, w.sat, saturated);
          errors++;
        end
      end
    end
  end

  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && pending_roots.size() == 0) begin
        repeat (80) @(posedge clk);
        if (errors == 0) $display("quadratic_root_solver: match");
        else $display("quadratic_root_solver: mismatch");
        $finish;
      end else if (idle_cycles > 2000) begin
        $display("quadratic_root_solver: mismatch");
        $finish;
      end
    end
  end
endmodule
